/* src/two_marker_byte_deframer_assert.svh */
// Assertion macros for the two-marker byte deframer.
// TMBD_ASSERT_SAME checks the consequent in the same cycle as the antecedent.
// TMBD_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef TWO_MARKER_BYTE_DEFRAMER_ASSERT_SVH
`define TWO_MARKER_BYTE_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmbd assertion failed");
`define TMBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmbd assertion failed");
`else
`define TMBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TMBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/tmbd_pkg.sv */
package tmbd_pkg;

  // Widths fixed by the byte stream and the result fields
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_TDATA_W = 24;

  // Payload buffer sizing
  localparam int PAYLOAD_LIMIT_DEF = 32;
  localparam int MAX_DEPTH         = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_FIRST  = 2'd0,
    REG_START_SECOND = 2'd1,
    REG_END_FIRST    = 2'd2,
    REG_END_SECOND   = 2'd3
  } tmbd_cfg_reg_t;

  // Parser and drain sequencer states
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_START2,
    ST_COLLECT,
    ST_END2,
    ST_DRAIN_RD,
    ST_DRAIN_WAIT
  } tmbd_state_t;

endpackage

/* src/tmbd_ram.sv */
module tmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/two_marker_byte_deframer.sv */
// Channel   | Direction | Ports                         | Contents
// ----------+-----------+-------------------------------+---------------------------------
// in        | slave     | in_tvalid/in_tready/in_tdata  | one received byte
// out       | master    | out_tvalid/out_tready/out_tdata/out_tlast | payload byte run
// cfg       | write     | cfg_we/cfg_addr/cfg_wdata     | four marker byte registers
//
// Hunting and collecting take one input byte per cycle while the output register is free.
// An accepted frame drains after its trailer byte with one RAM read and then one output load per
// byte, waiting on any output stall and taking no input; an empty frame's result is loaded by
// its trailer byte.
// Reset is synchronous, active low; it clears the parser, the counters, the output valid flag
// and the marker registers. Output stalls hold the output register and block input.
`include "two_marker_byte_deframer_assert.svh"

module two_marker_byte_deframer #(
  parameter int PAYLOAD_LIMIT = tmbd_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tmbd_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [tmbd_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] rx_byte
  input  logic [tmbd_pkg::BYTE_W-1:0]       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] payload_byte, [12:8] byte_position, [17:13] frame_length, [23:18] zero
  output logic [tmbd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  import tmbd_pkg::*;

  localparam int DEPTH = (PAYLOAD_LIMIT < MAX_DEPTH) ? PAYLOAD_LIMIT : MAX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD_W = OUT_TDATA_W - BYTE_W - 2 * CNT_W;

  // Marker registers
  logic [BYTE_W-1:0] start_first_r, start_second_r, end_first_r, end_second_r;

  // Control state
  tmbd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [CNT_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  // Datapath helpers
  logic              out_free;
  logic              in_fire;
  logic              parse_phase;
  logic              drain_phase;
  logic [CNT_W:0]    cnt_wide;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W:0]    rd_idx_inc;
  logic              ram_we;
  logic              ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;

  assign parse_phase = (state_r == ST_HUNT) || (state_r == ST_START2) ||
                       (state_r == ST_COLLECT) || (state_r == ST_END2);
  assign drain_phase = (state_r == ST_DRAIN_RD) || (state_r == ST_DRAIN_WAIT);
  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = parse_phase && out_free;
  assign in_fire     = in_tvalid && in_tready;
  assign cnt_wide    = {1'b0, cnt_r};
  assign cnt_inc     = cnt_wide + (CNT_W+1)'(1);
  assign rd_idx_inc  = {1'b0, rd_idx_r} + (CNT_W+1)'(1);

  // Payload store
  tmbd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Parse bytes, fill the store, drain an accepted frame
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_rd_en     = 1'b0;
    case (state_r)
      ST_HUNT: begin
        if (in_fire && (in_tdata == start_first_r)) begin
          state_nxt = ST_START2;
        end
      end
      ST_START2: begin
        if (in_fire) begin
          if (in_tdata == start_second_r) begin
            state_nxt = ST_COLLECT;
          end else begin
            state_nxt = ST_HUNT;
            cnt_nxt   = '0;
          end
        end
      end
      ST_COLLECT: begin
        if (in_fire) begin
          if (in_tdata == end_first_r) begin
            state_nxt = ST_END2;
          end else begin
            ram_we = 1'b1;
            // drop the frame once the buffer is full
            if (cnt_inc >= (CNT_W+1)'(DEPTH)) begin
              state_nxt = ST_HUNT;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = cnt_inc[CNT_W-1:0];
            end
          end
        end
      end
      ST_END2: begin
        if (in_fire) begin
          state_nxt = ST_HUNT;
          cnt_nxt   = '0;
          if (in_tdata == end_second_r) begin
            if (cnt_r == '0) begin
              // empty frame: one zero result
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_pos_nxt   = '0;
              out_len_nxt   = '0;
              out_last_nxt  = 1'b1;
            end else begin
              len_nxt    = cnt_r;
              rd_idx_nxt = '0;
              state_nxt  = ST_DRAIN_RD;
            end
          end
        end
      end
      ST_DRAIN_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_DRAIN_WAIT;
      end
      ST_DRAIN_WAIT: begin
        // load the read byte once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ram_rd_data;
          out_pos_nxt   = rd_idx_r;
          out_len_nxt   = len_r;
          out_last_nxt  = (rd_idx_inc == {1'b0, len_r});
          if (rd_idx_inc == {1'b0, len_r}) begin
            state_nxt = ST_HUNT;
          end else begin
            rd_idx_nxt = rd_idx_inc[CNT_W-1:0];
            state_nxt  = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      cnt_r       <= '0;
      len_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  // Marker register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r  <= '0;
      start_second_r <= '0;
      end_first_r    <= '0;
      end_second_r   <= '0;
    end else if (cfg_we) begin
      case (tmbd_cfg_reg_t'(cfg_addr))
        REG_START_FIRST:  start_first_r  <= cfg_wdata;
        REG_START_SECOND: start_second_r <= cfg_wdata;
        REG_END_FIRST:    end_first_r    <= cfg_wdata;
        REG_END_SECOND:   end_second_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {PAD_W'(0), out_len_r, out_pos_r, out_byte_r};

  // A byte that is not the last of its run leaves the drain sequencer running
  `TMBD_ASSERT_SAME(a_nonlast_in_drain, clk, rst_n, out_valid_r && !out_last_r, drain_phase)
  // A result's position lies inside its frame
  `TMBD_ASSERT_SAME(a_pos_in_len, clk, rst_n, out_valid_r && (out_len_r != '0), out_pos_r < out_len_r)
  // The fill count stays inside the store while collecting
  `TMBD_ASSERT_SAME(a_cnt_in_store, clk, rst_n, state_r == ST_COLLECT, cnt_wide < (CNT_W+1)'(DEPTH))
  // A read issued by the sequencer is always consumed in the following state
  `TMBD_ASSERT_NEXT(a_read_then_wait, clk, rst_n, state_r == ST_DRAIN_RD, state_r == ST_DRAIN_WAIT)

endmodule
